// File: sv/iirdf1_pkg.sv
`default_nettype none

package iirdf1_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned PROD_W    = 2 * DATA_W;
    localparam int unsigned ACC_W     = PROD_W + 3;
    localparam int unsigned NUM_X     = 4;
    localparam int unsigned NUM_Y     = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int          ORDER_DEF = 3;

    localparam logic signed [DATA_W-1:0] COEF_ONE = 32'sh1000_0000;
    localparam logic signed [DATA_W-1:0] Y_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Y_MIN    = 32'sh8000_0000;

    localparam logic OP_FILTER  = 1'b0;
    localparam logic OP_PRELOAD = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_B3 = 3'd3,
        REG_A0 = 3'd4,
        REG_A1 = 3'd5,
        REG_A2 = 3'd6,
        REG_A3 = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic clear;
        logic valid;
        logic sub;
    } t_mac_ctl;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [DATA_W-1:0] y;
    } t_div_res;

endpackage

`default_nettype wire

// File: sv/iirdf1_mac.sv
`default_nettype none

module iirdf1_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  iirdf1_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [iirdf1_pkg::DATA_W-1:0] i_coef,
    input  logic signed [iirdf1_pkg::DATA_W-1:0] i_data,
    output logic signed [iirdf1_pkg::ACC_W-1:0]  o_acc
);

    localparam int unsigned PROD_W = iirdf1_pkg::PROD_W;
    localparam int unsigned ACC_W  = iirdf1_pkg::ACC_W;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_valid;
    logic                     r_sub;
    logic signed [ACC_W-1:0]  r_acc;

    assign w_prod     = i_coef * i_data;
    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_ctl.valid && !i_ctl.clear;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_sub  <= i_ctl.sub;
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_valid) begin
            if (r_sub) begin
                r_acc <= r_acc - w_prod_ext;
            end else begin
                r_acc <= r_acc + w_prod_ext;
            end
        end
    end

    assign o_acc = r_acc;

    a_clear_zeroes_acc: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> (r_acc == '0)
    ) else $error("accumulator not cleared at start of sample");

endmodule

`default_nettype wire

// File: sv/iirdf1_div.sv
`default_nettype none

module iirdf1_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [iirdf1_pkg::ACC_W-1:0]  i_acc,
    input  logic signed [iirdf1_pkg::DATA_W-1:0] i_divisor,
    output iirdf1_pkg::t_div_res                 o_res
);

    localparam int unsigned DW    = iirdf1_pkg::DATA_W;
    localparam int unsigned ACC_W = iirdf1_pkg::ACC_W;
    localparam int unsigned MAG_W = ACC_W - 1;
    localparam int unsigned CNT_W = $clog2(DW);

    typedef enum logic [3:0] {
        D_IDLE  = 4'b0001,
        D_CHECK = 4'b0010,
        D_ITER  = 4'b0100,
        D_FIN   = 4'b1000
    } t_dstate;

    t_dstate           r_state;
    logic [MAG_W-1:0]  r_mag;
    logic [DW-1:0]     r_d;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_qneg;
    logic              r_zero;
    logic              r_acc_neg;
    logic              r_acc_nz;
    logic              r_done;
    logic              r_sat;
    logic [DW-1:0]     r_y;

    logic [ACC_W-1:0]  w_acc_abs;
    logic [DW-1:0]     w_d_abs;
    logic [DW:0]       w_trial;
    logic [DW:0]       w_diff;
    logic              w_ge;
    logic              w_ovf;

    assign w_acc_abs = i_acc[ACC_W-1] ? (~i_acc + 1'b1) : i_acc;
    assign w_d_abs   = i_divisor[DW-1] ? (~i_divisor + 1'b1) : i_divisor;
    assign w_trial   = {r_rem, r_quo[DW-1]};
    assign w_diff    = w_trial - {1'b0, r_d};
    assign w_ge      = !w_diff[DW];
    assign w_ovf     = r_mag[MAG_W-1:DW] >= {{(MAG_W-2*DW){1'b0}}, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                D_IDLE: begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_state <= D_CHECK;
                    end
                end
                D_CHECK: begin
                    if (r_zero || w_ovf) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        r_done  <= 1'b0;
                        r_state <= D_ITER;
                    end
                end
                D_ITER: begin
                    r_done <= 1'b0;
                    if (r_cnt == '1) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_mag     <= w_acc_abs[MAG_W-1:0];
                    r_d       <= w_d_abs;
                    r_qneg    <= i_acc[ACC_W-1] ^ i_divisor[DW-1];
                    r_zero    <= (i_divisor == '0);
                    r_acc_neg <= i_acc[ACC_W-1];
                    r_acc_nz  <= (i_acc != '0);
                end
            end
            D_CHECK: begin
                r_cnt <= '0;
                r_rem <= r_mag[2*DW-1:DW];
                r_quo <= r_mag[DW-1:0];
                if (r_zero) begin
                    r_sat <= 1'b1;
                    if (r_acc_neg) begin
                        r_y <= iirdf1_pkg::Y_MIN;
                    end else if (r_acc_nz) begin
                        r_y <= iirdf1_pkg::Y_MAX;
                    end else begin
                        r_y <= '0;
                    end
                end else if (w_ovf) begin
                    r_sat <= 1'b1;
                    r_y   <= r_qneg ? iirdf1_pkg::Y_MIN : iirdf1_pkg::Y_MAX;
                end
            end
            D_ITER: begin
                r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                r_quo <= {r_quo[DW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            D_FIN: begin
                if (r_qneg) begin
                    if (r_quo > iirdf1_pkg::Y_MIN) begin
                        r_sat <= 1'b1;
                        r_y   <= iirdf1_pkg::Y_MIN;
                    end else begin
                        r_sat <= 1'b0;
                        r_y   <= ~r_quo + 1'b1;
                    end
                end else begin
                    if (r_quo[DW-1]) begin
                        r_sat <= 1'b1;
                        r_y   <= iirdf1_pkg::Y_MAX;
                    end else begin
                        r_sat <= 1'b0;
                        r_y   <= r_quo;
                    end
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_res.done = r_done;
    assign o_res.sat  = r_sat;
    assign o_res.y    = r_y;

    a_rem_below_divisor: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == D_ITER) |-> (r_rem < r_d)
    ) else $error("partial remainder not below divisor");

    a_zero_div_flags: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_zero) |-> r_sat
    ) else $error("zero divisor result without saturation flag");

endmodule

`default_nettype wire

// File: sv/iir_direct_form_one_filter.sv
`default_nettype none

// Channel  Direction  Handshake                 Payload
// in       sink       i_in_valid / o_in_ready   i_opcode, i_sample_in, i_fill_input, i_fill_output
// out      source     o_out_valid / i_out_ready o_sample_out, o_saturated
// cfg      sink       i_cfg_we                  i_cfg_index, i_cfg_data
//
// A sample takes one multiply-accumulate per tap, then 32 steps of the restoring
// divider. Results saturated by the check before the divide finish early.
// A preload transfer completes in its accept cycle and gives no result.
// Synchronous active-low reset loads the coefficient defaults and zeroes both histories.
// A result waiting on the output register holds the sequencer in its done state; the
// next transfer is taken only once the sequencer is idle again.

module iir_direct_form_one_filter #(
    parameter int ORDER = iirdf1_pkg::ORDER_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic                                    i_opcode,
    input  logic signed [iirdf1_pkg::DATA_W-1:0]    i_sample_in,
    input  logic signed [iirdf1_pkg::DATA_W-1:0]    i_fill_input,
    input  logic signed [iirdf1_pkg::DATA_W-1:0]    i_fill_output,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [iirdf1_pkg::DATA_W-1:0]    o_sample_out,
    output logic                                    o_saturated,
    input  logic                                    i_cfg_we,
    input  logic [iirdf1_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [iirdf1_pkg::DATA_W-1:0]           i_cfg_data
);

    localparam int unsigned DW      = iirdf1_pkg::DATA_W;
    localparam int unsigned NUM_X   = iirdf1_pkg::NUM_X;
    localparam int unsigned NUM_Y   = iirdf1_pkg::NUM_Y;
    localparam int          NTAP    = (ORDER < 1) ? 1 : ((ORDER > 3) ? 3 : ORDER);
    localparam int unsigned NUM_TAP = 2 * NTAP + 1;
    localparam int unsigned TAP_W   = $clog2(NUM_TAP);
    localparam int unsigned X_IDX_W = $clog2(NUM_X);
    localparam int unsigned Y_IDX_W = $clog2(NUM_Y);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MAC   = 6'b000010,
        S_DRAIN = 6'b000100,
        S_START = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [TAP_W-1:0]       r_tap;
    logic signed [DW-1:0]   r_coef_b [NUM_X];
    logic signed [DW-1:0]   r_coef_a [NUM_X];
    logic signed [DW-1:0]   r_x [NUM_X];
    logic signed [DW-1:0]   r_y [NUM_Y];
    logic                   r_out_valid;
    logic signed [DW-1:0]   r_sample_out;
    logic                   r_saturated;

    logic                   w_in_xfer;
    logic                   w_out_xfer;
    logic                   w_out_free;
    logic                   w_fb_tap;
    logic [TAP_W-1:0]       w_tap_a;
    logic [TAP_W-1:0]       w_tap_y;
    logic signed [DW-1:0]   w_coef;
    logic signed [DW-1:0]   w_data;
    iirdf1_pkg::t_mac_ctl   w_mac_ctl;
    iirdf1_pkg::t_div_res   w_div_res;
    logic signed [iirdf1_pkg::ACC_W-1:0] w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = r_out_valid && i_out_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_fb_tap = r_tap > TAP_W'(NTAP);
    assign w_tap_a  = r_tap - TAP_W'(NTAP);
    assign w_tap_y  = w_tap_a - 1'b1;

    always_comb begin
        if (w_fb_tap) begin
            w_coef = r_coef_a[w_tap_a[X_IDX_W-1:0]];
            w_data = r_y[w_tap_y[Y_IDX_W-1:0]];
        end else begin
            w_coef = r_coef_b[r_tap[X_IDX_W-1:0]];
            w_data = r_x[r_tap[X_IDX_W-1:0]];
        end
    end

    assign w_mac_ctl.clear = w_in_xfer && (i_opcode == iirdf1_pkg::OP_FILTER);
    assign w_mac_ctl.valid = (r_state == S_MAC);
    assign w_mac_ctl.sub   = w_fb_tap;

    iirdf1_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coef  (w_coef),
        .i_data  (w_data),
        .o_acc   (w_acc)
    );

    iirdf1_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_START),
        .i_acc     (w_acc),
        .i_divisor (r_coef_a[0]),
        .o_res     (w_div_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer && (i_opcode == iirdf1_pkg::OP_FILTER)) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (r_tap == TAP_W'(NUM_TAP - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_START;
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_res.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_X; k++) begin
                r_coef_b[k] <= (k == 0) ? iirdf1_pkg::COEF_ONE : '0;
                r_coef_a[k] <= (k == 0) ? iirdf1_pkg::COEF_ONE : '0;
                r_x[k]      <= '0;
            end
            for (int k = 0; k < NUM_Y; k++) begin
                r_y[k] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (r_state == S_MAC) begin
                r_tap <= r_tap + 1'b1;
            end else begin
                r_tap <= '0;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    iirdf1_pkg::REG_B0: r_coef_b[0] <= i_cfg_data;
                    iirdf1_pkg::REG_B1: r_coef_b[1] <= i_cfg_data;
                    iirdf1_pkg::REG_B2: r_coef_b[2] <= i_cfg_data;
                    iirdf1_pkg::REG_B3: r_coef_b[3] <= i_cfg_data;
                    iirdf1_pkg::REG_A0: r_coef_a[0] <= i_cfg_data;
                    iirdf1_pkg::REG_A1: r_coef_a[1] <= i_cfg_data;
                    iirdf1_pkg::REG_A2: r_coef_a[2] <= i_cfg_data;
                    iirdf1_pkg::REG_A3: r_coef_a[3] <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_in_xfer) begin
                if (i_opcode == iirdf1_pkg::OP_PRELOAD) begin
                    for (int k = 0; k < NUM_X; k++) begin
                        r_x[k] <= i_fill_input;
                    end
                    for (int k = 0; k < NUM_Y; k++) begin
                        r_y[k] <= i_fill_output;
                    end
                end else begin
                    for (int k = 1; k < NUM_X; k++) begin
                        if (k <= NTAP) begin
                            r_x[k] <= r_x[k-1];
                        end
                    end
                    r_x[0] <= i_sample_in;
                end
            end

            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
                for (int k = 1; k < NUM_Y; k++) begin
                    if (k <= NTAP - 1) begin
                        r_y[k] <= r_y[k-1];
                    end
                end
                r_y[0] <= $signed(w_div_res.y);
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_sample_out <= $signed(w_div_res.y);
            r_saturated  <= w_div_res.sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_saturated  = r_saturated;

    a_div_done_in_div: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_div_res.done |-> (r_state == S_DIV)
    ) else $error("divider finished outside the divide phase");

    a_result_loaded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && w_out_free) |=>
            (o_out_valid && (o_sample_out == $past($signed(w_div_res.y))))
    ) else $error("result not presented after write-back");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iirdf1_pkg::*;

    localparam int TB_ORDER       = ORDER_DEF;
    localparam int TAPS           = (TB_ORDER < 1) ? 1 : ((TB_ORDER > 3) ? 3 : TB_ORDER);
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 128;

    localparam logic signed [DATA_W-1:0] COEF_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] COEF_MIN  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] COEF_HALF = 32'sh0800_0000;
    localparam logic signed [DATA_W-1:0] Q16_ONE   = 32'sh0001_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     sat;
    } t_filtered;

    typedef enum logic [1:0] {
        STYLE_STABLE,
        STYLE_WILD,
        STYLE_EXTREME,
        STYLE_NO_A0
    } t_coef_style;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_in_valid    = 1'b0;
    logic                     i_opcode      = OP_FILTER;
    logic signed [DATA_W-1:0] i_sample_in   = '0;
    logic signed [DATA_W-1:0] i_fill_input  = '0;
    logic signed [DATA_W-1:0] i_fill_output = '0;
    logic                     i_out_ready   = 1'b0;
    logic                     i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index   = '0;
    logic [DATA_W-1:0]        i_cfg_data    = '0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_sample_out;
    logic                     o_saturated;

    // filter state as the testbench sees it
    logic signed [DATA_W-1:0] coef_b [4];
    logic signed [DATA_W-1:0] coef_a [4];
    logic signed [DATA_W-1:0] x_hist [4];
    logic signed [DATA_W-1:0] y_hist [3];

    t_filtered pending_y [$];
    int        errors   = 0;
    int        idle_pct = 0;

    iir_direct_form_one_filter #(
        .ORDER(TB_ORDER)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_sample_in  (i_sample_in),
        .i_fill_input (i_fill_input),
        .i_fill_output(i_fill_output),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_saturated  (o_saturated),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_filtered filter_step(input logic signed [DATA_W-1:0] x);
        logic signed [127:0] acc;
        logic [127:0]        mag;
        logic [127:0]        quo;
        logic [63:0]         dvs;
        logic                negative;
        t_filtered           r;
        int                  k;
        for (k = TAPS; k > 0; k--) x_hist[k] = x_hist[k-1];
        x_hist[0] = x;
        acc = '0;
        for (k = 0; k <= TAPS; k++) acc += coef_b[k] * x_hist[k];
        for (k = 1; k <= TAPS; k++) acc -= coef_a[k] * y_hist[k-1];
        negative = acc[127];
        r.sat    = 1'b0;
        if (coef_a[0] == 0) begin
            r.sat    = 1'b1;
            r.sample = negative ? Y_MIN : ((acc != 0) ? Y_MAX : '0);
        end else begin
            mag = negative ? -acc : acc;
            dvs = coef_a[0];
            if (coef_a[0] < 0) begin
                dvs      = -dvs;
                negative = !negative;
            end
            quo = mag / {64'd0, dvs};
            if (negative) begin
                if (quo > 128'h8000_0000) begin
                    r.sample = Y_MIN;
                    r.sat    = 1'b1;
                end else begin
                    r.sample = -quo[DATA_W-1:0];
                end
            end else if (quo > 128'h7FFF_FFFF) begin
                r.sample = Y_MAX;
                r.sat    = 1'b1;
            end else begin
                r.sample = quo[DATA_W-1:0];
            end
        end
        for (k = TAPS - 1; k > 0; k--) y_hist[k] = y_hist[k-1];
        y_hist[0] = r.sample;
        return r;
    endfunction

    task automatic send_item(input logic op, input logic signed [DATA_W-1:0] smp,
                             input logic signed [DATA_W-1:0] fin,
                             input logic signed [DATA_W-1:0] fout);
        int gap;
        int k;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(8, 1);
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_sample_in   <= smp;
        i_fill_input  <= fin;
        i_fill_output <= fout;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        if (op == OP_PRELOAD) begin
            for (k = 0; k < 4; k++) x_hist[k] = fin;
            for (k = 0; k < 3; k++) y_hist[k] = fout;
        end else begin
            pending_y.push_back(filter_step(smp));
        end
    endtask

    // stop sending, let every result out, then give the sequencer time to go idle
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_y.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_coef(input t_reg_idx idx, input logic signed [DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx <= REG_B3) coef_b[idx[1:0]] = val;
        else coef_a[idx[1:0]] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_filter(input logic signed [DATA_W-1:0] b0, b1, b2, b3,
                                  input logic signed [DATA_W-1:0] a0, a1, a2, a3);
        drain();
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_B3, b3);
        write_coef(REG_A0, a0);
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
        write_coef(REG_A3, a3);
    endtask

    // reset coefficients give y = x, so the sample range passes straight through
    task automatic test_passthrough();
        send_item(OP_FILTER, '0, COEF_MAX, COEF_MIN);
        send_item(OP_FILTER, 32'sd1, COEF_MIN, COEF_MAX);
        send_item(OP_FILTER, -32'sd1, '0, -32'sd1);
        send_item(OP_FILTER, Y_MAX, -32'sd1, '0);
        send_item(OP_FILTER, Y_MIN, '0, '0);
        send_item(OP_FILTER, Q16_ONE, '0, '0);
    endtask

    task automatic test_preload();
        program_filter(COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE,
                       COEF_ONE, COEF_HALF, COEF_HALF, COEF_HALF);
        send_item(OP_PRELOAD, Y_MAX, Y_MIN, Y_MAX);
        send_item(OP_FILTER, '0, '0, '0);
        send_item(OP_FILTER, Q16_ONE, '0, '0);
        send_item(OP_PRELOAD, '0, Q16_ONE, -Q16_ONE);
        send_item(OP_FILTER, 2 * Q16_ONE, '0, '0);
        send_item(OP_FILTER, 2 * Q16_ONE, '0, '0);
    endtask

    task automatic test_zero_divisor();
        program_filter(COEF_ONE, '0, '0, '0, '0, '0, '0, '0);
        send_item(OP_PRELOAD, '0, '0, '0);
        send_item(OP_FILTER, 32'sd5, '0, '0);
        send_item(OP_FILTER, -32'sd5, '0, '0);
        send_item(OP_FILTER, '0, '0, '0);
    endtask

    // clipping on both bounds, a negative divisor, and the exact lower bound
    task automatic test_saturation();
        program_filter(COEF_MAX, '0, '0, '0, 32'sd1, '0, '0, '0);
        send_item(OP_FILTER, Y_MAX, '0, '0);
        send_item(OP_FILTER, Y_MIN, '0, '0);
        program_filter(COEF_MIN, '0, '0, '0, COEF_MIN, '0, '0, '0);
        send_item(OP_FILTER, Y_MIN, '0, '0);
        send_item(OP_FILTER, Y_MAX, '0, '0);
    endtask

    task automatic test_random_phases();
        logic signed [DATA_W-1:0] nb [4];
        logic signed [DATA_W-1:0] na [4];
        t_coef_style              style;
        int                       p;
        int                       n;
        int                       k;
        for (p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1 || p % 2 == 0) style = STYLE_STABLE;
            else style = t_coef_style'(1 + (p / 2) % 3);
            for (k = 0; k < 4; k++) begin
                case (style)
                    STYLE_STABLE: begin
                        nb[k] = $signed($urandom) >>> 4;
                        na[k] = $signed($urandom) >>> 6;
                    end
                    STYLE_EXTREME: begin
                        case ($urandom_range(3))
                            0: nb[k] = COEF_MAX;
                            1: nb[k] = COEF_MIN;
                            2: nb[k] = '0;
                            default: nb[k] = COEF_ONE;
                        endcase
                        na[k] = $urandom_range(1) ? COEF_MAX : COEF_MIN;
                    end
                    default: begin
                        nb[k] = $urandom;
                        na[k] = $urandom;
                    end
                endcase
            end
            case (style)
                STYLE_STABLE: na[0] = $urandom_range(1) ? COEF_ONE : $signed($urandom) >>> 2;
                STYLE_EXTREME: begin
                    case ($urandom_range(3))
                        0: na[0] = 32'sd1;
                        1: na[0] = -32'sd1;
                        2: na[0] = COEF_MIN;
                        default: na[0] = COEF_MAX;
                    endcase
                end
                STYLE_NO_A0: na[0] = '0;
                default: ;
            endcase
            program_filter(nb[0], nb[1], nb[2], nb[3], na[0], na[1], na[2], na[3]);
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 20;
                default: idle_pct = 60;
            endcase
            if (p == NUM_PHASES - 1) idle_pct = 0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_item(($urandom_range(99) < 5) ? OP_PRELOAD : OP_FILTER,
                          $signed($urandom) >>> $urandom_range(14),
                          $signed($urandom) >>> $urandom_range(14),
                          $signed($urandom) >>> $urandom_range(14));
            end
        end
    endtask

    initial begin
        coef_b = '{COEF_ONE, '0, '0, '0};
        coef_a = '{COEF_ONE, '0, '0, '0};
        x_hist = '{'0, '0, '0, '0};
        y_hist = '{'0, '0, '0};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 30;
        test_passthrough();
        test_preload();
        test_zero_divisor();
        test_saturation();
        test_random_phases();
        drain();
        if (errors == 0) begin
            $display("[iir_direct_form_one_filter] OK");
        end else begin
            $display("[iir_direct_form_one_filter] ERROR");
        end
        $finish;
    end

    initial begin : out_stall
        int n;
        forever begin
            @(negedge i_clk);
            if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                n = $urandom_range(8, 1);
                i_out_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_filtered want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_y.size() == 0) begin
                $display("%0t ns: unexpected result, sample_out %0d saturated %0b",
                         $time, o_sample_out, o_saturated);
                errors++;
            end else begin
                want = pending_y.pop_front();
                if (o_sample_out !== want.sample) begin
                    $display("%0t ns: sample_out expected %0d, got %0d",
                             $time, want.sample, o_sample_out);
                    errors++;
                end
                if (o_saturated !== want.sat) begin
                    $display("%0t ns: saturated expected %0b, got %0b",
                             $time, want.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    // no transfer on either channel for too long means the block has hung
    initial begin : watchdog
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("%0t ns: timeout, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[iir_direct_form_one_filter] ERROR");
        $finish;
    end

endmodule

// File: files.f
sv/iirdf1_pkg.sv
sv/iirdf1_mac.sv
sv/iirdf1_div.sv
sv/iir_direct_form_one_filter.sv
sim/tb_top.sv
